>>> hw/rtl/block_mapping_flash_translation_defines.svh
// Assertion helpers for the flash translation block.
`ifndef BLOCK_MAPPING_FLASH_TRANSLATION_DEFINES_SVH
`define BLOCK_MAPPING_FLASH_TRANSLATION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bmft_pkg.sv
package bmft_pkg;

  localparam int SECTOR_W   = 13;
  localparam int PAGE_NUM_W = 13;
  localparam int BLK_NUM_W  = 8;

  typedef enum logic [1:0] {
    FOP_READ  = 2'd0,
    FOP_PROG  = 2'd1,
    FOP_COPY  = 2'd2,
    FOP_ERASE = 2'd3
  } flash_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_RANGE    = 2'd3
  } ftl_status_t;

  // What the output register is loaded with.
  typedef enum logic [2:0] {
    EM_RANGE      = 3'd0,
    EM_UNMAPPED   = 3'd1,
    EM_NO_FREE    = 3'd2,
    EM_READ       = 3'd3,
    EM_PROG_HOST  = 3'd4,
    EM_PROG_MERGE = 3'd5,
    EM_COPY       = 3'd6,
    EM_ERASE      = 3'd7
  } emit_kind_t;

  typedef struct packed {
    logic       clr_en;
    logic       cap_in;
    logic       div_mul;
    logic       div_fix;
    logic       sel_blk;
    logic       cap_old;
    logic       alloc;
    logic       pw_mark;
    logic       pw_merge;
    logic       pw_erase;
    logic       swap;
    logic       merge_step;
    logic       emit;
    emit_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic is_write;
    logic out_of_range;
    logic mapped;
    logic no_free;
    logic new_blk;
    logic page_hit;
    logic m_prog;
    logic m_copy;
    logic m_last;
  } dp_sts_t;

endpackage

>>> hw/rtl/bmft_ctrl.sv
module bmft_ctrl import bmft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DIV1   = 11'b000_0000_0100,
    S_DIV2   = 11'b000_0000_1000,
    S_MAP_RD = 11'b000_0001_0000,
    S_DECIDE = 11'b000_0010_0000,
    S_PW_RD  = 11'b000_0100_0000,
    S_PW_CHK = 11'b000_1000_0000,
    S_MERGE  = 11'b001_0000_0000,
    S_FIN1   = 11'b010_0000_0000,
    S_FIN2   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = EM_RANGE;
    state_nxt = state_r;
    in_ready  = 1'b0;
    need      = sts.m_prog | sts.m_copy;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_MAP_RD;
      end
      S_MAP_RD: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_of_range) begin
          cmd.kind = EM_RANGE;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!sts.is_write) begin
          cmd.kind = sts.mapped ? EM_READ : EM_UNMAPPED;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!sts.mapped && sts.no_free) begin
          cmd.kind = EM_NO_FREE;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.sel_blk = 1'b1;
          state_nxt   = S_PW_RD;
        end
      end
      S_PW_RD: begin
        state_nxt = S_PW_CHK;
      end
      S_PW_CHK: begin
        cmd.cap_old = 1'b1;
        cmd.kind    = EM_PROG_HOST;
        if (sts.new_blk || !sts.page_hit) begin
          if (sts.out_free) begin
            cmd.pw_mark = 1'b1;
            cmd.alloc   = sts.new_blk;
            cmd.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.kind = sts.m_prog ? EM_PROG_MERGE : EM_COPY;
        // pages that are neither the host page nor valid are skipped silently
        if (!need || sts.out_free) begin
          cmd.emit       = need;
          cmd.merge_step = 1'b1;
          if (sts.m_last) state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        cmd.pw_merge = 1'b1;
        state_nxt    = S_FIN2;
      end
      S_FIN2: begin
        cmd.kind = EM_ERASE;
        if (sts.out_free) begin
          cmd.pw_erase = 1'b1;
          cmd.swap     = 1'b1;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/bmft_dp.sv
module bmft_dp import bmft_pkg::*; #(
  parameter int PAGES_IN_BLOCK    = 32,
  parameter int DATA_BLOCK_COUNT  = 255,
  parameter int TOTAL_BLOCK_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_command,
  input  logic [SECTOR_W-1:0]   in_logical_sector,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_flash_op,
  output logic [PAGE_NUM_W-1:0] out_target_page,
  output logic [PAGE_NUM_W-1:0] out_source_page,
  output logic [BLK_NUM_W-1:0]  out_erase_block_number,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  localparam int PAGE_W = $clog2(PAGES_IN_BLOCK);
  localparam int LBN_W  = $clog2(((1 << SECTOR_W) - 1) / PAGES_IN_BLOCK + 1);
  localparam int BLK_W  = $clog2(DATA_BLOCK_COUNT + 1);
  localparam int MAP_AW = $clog2(DATA_BLOCK_COUNT);
  localparam int PW_AW  = $clog2(TOTAL_BLOCK_COUNT);
  localparam int CLR_N  = (DATA_BLOCK_COUNT > TOTAL_BLOCK_COUNT) ?
                          DATA_BLOCK_COUNT : TOTAL_BLOCK_COUNT;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam int PROD_W = 2 * SECTOR_W;
  // floor(2^13 / P): quotient estimate is low by at most one
  localparam int DIV_M  = (1 << SECTOR_W) / PAGES_IN_BLOCK;

  function automatic logic [PAGE_NUM_W-1:0] phys(input logic [BLK_W-1:0] b,
                                                 input logic [PAGE_W-1:0] p);
    phys = PAGE_NUM_W'(32'(b) * PAGES_IN_BLOCK + 32'(p));
  endfunction

  logic                      cmd_r;
  logic [SECTOR_W-1:0]       sector_r;
  logic [PROD_W-1:0]         prod_r;
  logic [LBN_W-1:0]          lbn_r;
  logic [PAGE_W-1:0]         page_r;
  logic [BLK_W:0]            map_q_r;
  logic [BLK_W-1:0]          blk_r;
  logic                      new_r;
  logic [PAGES_IN_BLOCK-1:0] pw_q_r;
  logic [PAGES_IN_BLOCK-1:0] old_r;
  logic [BLK_W-1:0]          spare_r;
  logic [BLK_W-1:0]          next_r;
  logic [PAGE_W-1:0]         idx_r;
  logic [CLR_W-1:0]          clr_r;
  logic                      out_valid_r;

  logic [BLK_W:0]            map_mem [DATA_BLOCK_COUNT];
  logic [PAGES_IN_BLOCK-1:0] pw_mem  [TOTAL_BLOCK_COUNT];

  logic                      map_we;
  logic [MAP_AW-1:0]         map_wa;
  logic [BLK_W:0]            map_wd;
  logic                      pw_we;
  logic [PW_AW-1:0]          pw_wa;
  logic [PAGES_IN_BLOCK-1:0] pw_wd;

  logic [LBN_W-1:0]          q_est;
  logic [SECTOR_W-1:0]       rem;
  logic [PAGES_IN_BLOCK-1:0] page_bit;
  logic [PAGES_IN_BLOCK-1:0] old_now;
  logic                      blk_in_dev;
  logic                      spare_in_dev;

  logic [1:0]                op_nxt;
  logic [PAGE_NUM_W-1:0]     tgt_nxt;
  logic [PAGE_NUM_W-1:0]     src_nxt;
  logic [BLK_NUM_W-1:0]      eb_nxt;
  logic [1:0]                st_nxt;
  logic                      last_nxt;

  always_comb begin
    page_bit         = '0;
    page_bit[page_r] = 1'b1;
  end

  assign blk_in_dev   = 32'(blk_r) < 32'(TOTAL_BLOCK_COUNT);
  assign spare_in_dev = 32'(spare_r) < 32'(TOTAL_BLOCK_COUNT);
  // marks of a block beyond the device read as clean
  assign old_now      = blk_in_dev ? pw_q_r : '0;

  assign q_est = LBN_W'(prod_r >> SECTOR_W);
  assign rem   = sector_r - SECTOR_W'(32'(q_est) * PAGES_IN_BLOCK);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      next_r      <= '0;
      spare_r     <= BLK_W'(DATA_BLOCK_COUNT);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_r <= clr_r + CLR_W'(1);
      if (cmd.alloc) next_r <= next_r + BLK_W'(1);
      if (cmd.swap) spare_r <= blk_r;
      if (cmd.merge_step) idx_r <= sts.m_last ? '0 : idx_r + PAGE_W'(1);
      out_valid_r <= cmd.emit | (out_valid_r & ~out_ready);
    end
  end

  // request decode and working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_r    <= in_command;
      sector_r <= in_logical_sector;
    end
    if (cmd.div_mul) prod_r <= PROD_W'(sector_r) * PROD_W'(DIV_M);
    if (cmd.div_fix) begin
      if (rem >= SECTOR_W'(PAGES_IN_BLOCK)) begin
        lbn_r  <= q_est + LBN_W'(1);
        page_r <= PAGE_W'(rem - SECTOR_W'(PAGES_IN_BLOCK));
      end else begin
        lbn_r  <= q_est;
        page_r <= PAGE_W'(rem);
      end
    end
    if (cmd.sel_blk) begin
      blk_r <= map_q_r[BLK_W] ? map_q_r[BLK_W-1:0] : next_r;
      new_r <= ~map_q_r[BLK_W];
    end
    if (cmd.cap_old) old_r <= old_now;
  end

  // block map: mapped flag plus physical block per logical block
  always_comb begin
    map_we = 1'b0;
    map_wa = MAP_AW'(lbn_r);
    map_wd = '0;
    if (cmd.clr_en) begin
      map_we = 32'(clr_r) < 32'(DATA_BLOCK_COUNT);
      map_wa = MAP_AW'(clr_r);
    end else if (cmd.alloc) begin
      map_we = 1'b1;
      map_wd = {1'b1, blk_r};
    end else if (cmd.swap) begin
      map_we = 1'b1;
      map_wd = {1'b1, spare_r};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q_r <= map_mem[MAP_AW'(lbn_r)];
  end

  // page-written marks per physical block
  always_comb begin
    pw_we = 1'b0;
    pw_wa = PW_AW'(blk_r);
    pw_wd = '0;
    if (cmd.clr_en) begin
      pw_we = 32'(clr_r) < 32'(TOTAL_BLOCK_COUNT);
      pw_wa = PW_AW'(clr_r);
    end else if (cmd.pw_mark) begin
      pw_we = blk_in_dev;
      pw_wd = old_now | page_bit;
    end else if (cmd.pw_merge) begin
      pw_we = spare_in_dev;
      pw_wa = PW_AW'(spare_r);
      pw_wd = old_r | page_bit;
    end else if (cmd.pw_erase) begin
      pw_we = blk_in_dev;
    end
  end

  always_ff @(posedge clk) begin
    if (pw_we) pw_mem[pw_wa] <= pw_wd;
    pw_q_r <= pw_mem[PW_AW'(blk_r)];
  end

  // result formatting
  always_comb begin
    op_nxt   = FOP_READ;
    tgt_nxt  = '0;
    src_nxt  = '0;
    eb_nxt   = '0;
    st_nxt   = ST_OK;
    last_nxt = 1'b1;
    case (cmd.kind)
      EM_RANGE:    st_nxt = ST_RANGE;
      EM_UNMAPPED: st_nxt = ST_UNMAPPED;
      EM_NO_FREE:  st_nxt = ST_NO_FREE;
      EM_READ:     tgt_nxt = phys(map_q_r[BLK_W-1:0], page_r);
      EM_PROG_HOST: begin
        op_nxt  = FOP_PROG;
        tgt_nxt = phys(blk_r, page_r);
      end
      EM_PROG_MERGE: begin
        op_nxt   = FOP_PROG;
        tgt_nxt  = phys(spare_r, idx_r);
        last_nxt = 1'b0;
      end
      EM_COPY: begin
        op_nxt   = FOP_COPY;
        tgt_nxt  = phys(spare_r, idx_r);
        src_nxt  = phys(blk_r, idx_r);
        last_nxt = 1'b0;
      end
      EM_ERASE: begin
        op_nxt = FOP_ERASE;
        eb_nxt = BLK_NUM_W'(blk_r);
      end
      default: st_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_flash_op           <= op_nxt;
      out_target_page        <= tgt_nxt;
      out_source_page        <= src_nxt;
      out_erase_block_number <= eb_nxt;
      out_status             <= st_nxt;
      out_last               <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.clr_last     = clr_r == CLR_W'(CLR_N - 1);
    sts.out_free     = ~out_valid_r | out_ready;
    sts.is_write     = cmd_r;
    sts.out_of_range = 32'(lbn_r) >= 32'(DATA_BLOCK_COUNT);
    sts.mapped       = map_q_r[BLK_W];
    sts.no_free      = next_r == BLK_W'(DATA_BLOCK_COUNT);
    sts.new_blk      = new_r;
    sts.page_hit     = |(old_now & page_bit);
    sts.m_prog       = idx_r == page_r;
    sts.m_copy       = old_r[idx_r] & (idx_r != page_r);
    sts.m_last       = idx_r == PAGE_W'(PAGES_IN_BLOCK - 1);
  end

endmodule

>>> hw/rtl/block_mapping_flash_translation.sv
// Block-mapped flash translation: one host read or write request in, a run of flash
// operations out, the final one flagged by out_last. Requests are handled one at a time.
// A read, or any request that ends in an error status, is answered after the block-map lookup;
// a write that programs a clean page also reads the page-written marks; a write that merges
// into the spare block walks every page of the block on the merge sequencer, one page per
// cycle while the output register can take each operation, then erases the old block. Each
// operation leaves through the output register, which out_ready can hold. After reset the
// block map and the page-written memories are cleared, one row per cycle, over the larger
// of DATA_BLOCK_COUNT and TOTAL_BLOCK_COUNT rows, during which in_ready stays low.
`include "block_mapping_flash_translation_defines.svh"

module block_mapping_flash_translation import bmft_pkg::*; #(
  parameter int PAGES_IN_BLOCK    = 32,
  parameter int DATA_BLOCK_COUNT  = 255,
  parameter int TOTAL_BLOCK_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [SECTOR_W-1:0]   in_logical_sector,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_flash_op,
  output logic [PAGE_NUM_W-1:0] out_target_page,
  output logic [PAGE_NUM_W-1:0] out_source_page,
  output logic [BLK_NUM_W-1:0]  out_erase_block_number,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bmft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  bmft_dp #(
    .PAGES_IN_BLOCK    (PAGES_IN_BLOCK),
    .DATA_BLOCK_COUNT  (DATA_BLOCK_COUNT),
    .TOTAL_BLOCK_COUNT (TOTAL_BLOCK_COUNT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_command             (in_command),
    .in_logical_sector      (in_logical_sector),
    .cmd                    (dp_cmd),
    .sts                    (dp_sts),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_flash_op           (out_flash_op),
    .out_target_page        (out_target_page),
    .out_source_page        (out_source_page),
    .out_erase_block_number (out_erase_block_number),
    .out_status             (out_status),
    .out_last               (out_last)
  );

  `BMFT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")
  `BMFT_ASSERT_SAME(a_emit_when_free, dp_cmd.emit, dp_sts.out_free, "output register overwritten")
  `BMFT_ASSERT_SAME(a_error_is_last, out_valid && (out_status != ST_OK), out_last && (out_flash_op == FOP_READ), "error result not final")
  `BMFT_ASSERT_SAME(a_inner_is_merge, out_valid && !out_last, (out_flash_op == FOP_PROG) || (out_flash_op == FOP_COPY), "non-final result outside merge")

endmodule

>>> test/block_mapping_flash_translation_checker.sv
`timescale 1ns / 100ps

module block_mapping_flash_translation_checker import bmft_pkg::*; #(
  parameter int PAGES_IN_BLOCK    = 32,
  parameter int DATA_BLOCK_COUNT  = 255,
  parameter int TOTAL_BLOCK_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_command,
  input  logic [SECTOR_W-1:0]   in_logical_sector,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_flash_op,
  input  logic [PAGE_NUM_W-1:0] out_target_page,
  input  logic [PAGE_NUM_W-1:0] out_source_page,
  input  logic [BLK_NUM_W-1:0]  out_erase_block_number,
  input  logic [1:0]            out_status,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    pending
);

  localparam int PIB = PAGES_IN_BLOCK;
  localparam int DBC = DATA_BLOCK_COUNT;
  localparam int TBC = TOTAL_BLOCK_COUNT;

  typedef struct packed {
    flash_op_t             op;
    logic [PAGE_NUM_W-1:0] tgt;
    logic [PAGE_NUM_W-1:0] src;
    logic [BLK_NUM_W-1:0]  eblk;
    ftl_status_t           st;
    logic                  last;
  } flash_op_rec_t;

  // Shadow of the translation tables.
  int             phys_of_lbn [0:DBC];
  logic           lbn_valid   [0:DBC-1];
  logic [PIB-1:0] written_pages [0:TBC-1];
  int             fresh_blk;

  flash_op_rec_t  expected_ops [$];
  flash_op_rec_t  want;
  int             err_n = 0;

  function automatic logic [PAGE_NUM_W-1:0] flash_page(int blk, int pg);
    return PAGE_NUM_W'(blk * PIB + pg);
  endfunction

  task automatic queue_op(flash_op_t op, logic [PAGE_NUM_W-1:0] tgt,
                          logic [PAGE_NUM_W-1:0] src, logic [BLK_NUM_W-1:0] eblk,
                          ftl_status_t st, logic last);
    flash_op_rec_t r;
    r.op   = op;
    r.tgt  = tgt;
    r.src  = src;
    r.eblk = eblk;
    r.st   = st;
    r.last = last;
    expected_ops.push_back(r);
  endtask

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] exp_v);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp_v);
    err_n++;
  endtask

  task automatic translate_request(logic cmd, logic [SECTOR_W-1:0] sector);
    int             lbn;
    int             pg;
    int             blk;
    int             spare;
    logic [PIB-1:0] old_bits;
    logic [PIB-1:0] pg_bit;
    lbn = int'(sector) / PIB;
    pg  = int'(sector) % PIB;
    pg_bit = '0;
    pg_bit[pg] = 1'b1;
    if (lbn >= DBC) begin
      queue_op(FOP_READ, '0, '0, '0, ST_RANGE, 1'b1);
    end else if (!cmd) begin
      if (!lbn_valid[lbn])
        queue_op(FOP_READ, '0, '0, '0, ST_UNMAPPED, 1'b1);
      else
        queue_op(FOP_READ, flash_page(phys_of_lbn[lbn], pg), '0, '0, ST_OK, 1'b1);
    end else if (!lbn_valid[lbn]) begin
      if (fresh_blk >= DBC) begin
        queue_op(FOP_READ, '0, '0, '0, ST_NO_FREE, 1'b1);
      end else begin
        blk = fresh_blk;
        fresh_blk++;
        phys_of_lbn[lbn] = blk;
        lbn_valid[lbn]   = 1'b1;
        if (blk < TBC) written_pages[blk] = written_pages[blk] | pg_bit;
        queue_op(FOP_PROG, flash_page(blk, pg), '0, '0, ST_OK, 1'b1);
      end
    end else begin
      blk = phys_of_lbn[lbn];
      old_bits = (blk < TBC) ? written_pages[blk] : '0;
      if ((old_bits & pg_bit) == '0) begin
        if (blk < TBC) written_pages[blk] = old_bits | pg_bit;
        queue_op(FOP_PROG, flash_page(blk, pg), '0, '0, ST_OK, 1'b1);
      end else begin
        // rewrite of a dirty page: rebuild the block in the spare, then erase the old one
        spare = phys_of_lbn[DBC];
        for (int i = 0; i < PIB; i++) begin
          if (i == pg)
            queue_op(FOP_PROG, flash_page(spare, i), '0, '0, ST_OK, 1'b0);
          else if (old_bits[i])
            queue_op(FOP_COPY, flash_page(spare, i), flash_page(blk, i), '0, ST_OK, 1'b0);
        end
        if (spare < TBC) written_pages[spare] = old_bits | pg_bit;
        if (blk < TBC) written_pages[blk] = '0;
        phys_of_lbn[lbn] = spare;
        phys_of_lbn[DBC] = blk;
        queue_op(FOP_ERASE, '0, '0, BLK_NUM_W'(blk), ST_OK, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DBC; k++) phys_of_lbn[k] = 0;
      for (int k = 0; k < DBC; k++) lbn_valid[k] = 1'b0;
      for (int k = 0; k < TBC; k++) written_pages[k] = '0;
      phys_of_lbn[DBC] = DBC;
      fresh_blk = 0;
      expected_ops.delete();
    end else begin
      // results first, so a request taken on this edge cannot match them
      if (out_valid && out_ready) begin
        if (expected_ops.size() == 0) begin
          flag_mismatch("result with no request pending", 16'(out_flash_op), 16'hFFFF);
        end else begin
          want = expected_ops.pop_front();
          if (out_flash_op !== want.op)
            flag_mismatch("flash_op", 16'(out_flash_op), 16'(want.op));
          if (out_target_page !== want.tgt)
            flag_mismatch("target_page", 16'(out_target_page), 16'(want.tgt));
          if (out_source_page !== want.src)
            flag_mismatch("source_page", 16'(out_source_page), 16'(want.src));
          if (out_erase_block_number !== want.eblk)
            flag_mismatch("erase_block_number", 16'(out_erase_block_number), 16'(want.eblk));
          if (out_status !== want.st)
            flag_mismatch("status", 16'(out_status), 16'(want.st));
          if (out_last !== want.last)
            flag_mismatch("last", 16'(out_last), 16'(want.last));
        end
      end
      if (in_valid && in_ready)
        translate_request(in_command, in_logical_sector);
    end
    pending    <= expected_ops.size();
    fail_count <= err_n;
  end

endmodule

>>> test/block_mapping_flash_translation_tb.sv
`timescale 1ns / 100ps

module block_mapping_flash_translation_tb import bmft_pkg::*; ();

  localparam int PIB        = 32;
  localparam int DBC        = 255;
  localparam int TBC        = 256;
  localparam int STALL_MAX  = 3000;
  localparam int HOLD_LEN   = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_command;
  logic [SECTOR_W-1:0]   in_logical_sector;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_flash_op;
  logic [PAGE_NUM_W-1:0] out_target_page;
  logic [PAGE_NUM_W-1:0] out_source_page;
  logic [BLK_NUM_W-1:0]  out_erase_block_number;
  logic [1:0]            out_status;
  logic                  out_last;
  int                    fail_count;
  int                    pending;

  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   stall_cnt = 0;

  always #5 clk = ~clk;

  block_mapping_flash_translation #(
    .PAGES_IN_BLOCK(PIB),
    .DATA_BLOCK_COUNT(DBC),
    .TOTAL_BLOCK_COUNT(TBC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_logical_sector(in_logical_sector),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_flash_op(out_flash_op),
    .out_target_page(out_target_page),
    .out_source_page(out_source_page),
    .out_erase_block_number(out_erase_block_number),
    .out_status(out_status),
    .out_last(out_last)
  );

  block_mapping_flash_translation_checker #(
    .PAGES_IN_BLOCK(PIB),
    .DATA_BLOCK_COUNT(DBC),
    .TOTAL_BLOCK_COUNT(TBC)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_logical_sector(in_logical_sector),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_flash_op(out_flash_op),
    .out_target_page(out_target_page),
    .out_source_page(out_source_page),
    .out_erase_block_number(out_erase_block_number),
    .out_status(out_status),
    .out_last(out_last),
    .fail_count(fail_count),
    .pending(pending)
  );

  task automatic issue_request(logic cmd, logic [SECTOR_W-1:0] sec);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_logical_sector <= sec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly traffic on a few hot blocks so rewrites turn into merges.
  task automatic random_burst(int count);
    int r;
    int lbn;
    int pg;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      lbn = $urandom_range(0, 3);
      pg  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, PIB - 1);
      if (r < 40)
        issue_request(1'b1, SECTOR_W'(lbn * PIB + pg));
      else if (r < 60)
        issue_request(1'b0, SECTOR_W'(lbn * PIB + pg));
      else if (r < 85)
        issue_request(1'b1, SECTOR_W'($urandom_range(0, DBC - 1) * PIB + pg));
      else if (r < 92)
        issue_request(1'b0, SECTOR_W'($urandom_range(0, DBC - 1) * PIB + pg));
      else if (r < 96)
        issue_request(1'($urandom_range(0, 1)), SECTOR_W'($urandom_range(DBC * PIB, 8191)));
      else
        issue_request(1'($urandom_range(0, 1)), SECTOR_W'($urandom_range(0, 8191)));
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    forever begin
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles with no request or result moving
  initial begin
    while (stall_cnt < STALL_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cnt = 0;
      else
        stall_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_command        <= 1'b0;
    in_logical_sector <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 26;
    rcv_idle_pct = 84;
    issue_request(1'b0, 13'd0);          // read, block unmapped
    issue_request(1'b1, 13'd0);          // first write allocates
    issue_request(1'b0, 13'd0);
    issue_request(1'b1, 13'd31);         // clean page, in place
    issue_request(1'b0, 13'd31);
    issue_request(1'b0, 13'd5);          // mapped block, page never written
    issue_request(1'b1, 13'd0);          // dirty page: merge into spare
    issue_request(1'b1, 13'd0);          // and back again
    issue_request(1'b0, 13'd1);
    issue_request(1'b0, 13'd8160);       // first sector past the end
    issue_request(1'b1, 13'd8191);
    issue_request(1'b0, 13'd8190);
    issue_request(1'b1, 13'd8159);       // last logical block, last page
    issue_request(1'b0, 13'd8159);
    issue_request(1'b1, 13'd8159);
    issue_request(1'b1, 13'd4096);
    issue_request(1'b1, 13'd2730);
    issue_request(1'b1, 13'd5461);
    issue_request(1'b0, 13'd5461);
    random_burst(90);
    drain_wait();

    snd_idle_pct = 84;
    rcv_idle_pct = 26;
    random_burst(90);
    drain_wait();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_go = 1'b1;
    random_burst(60);
    // fill a whole block, then rewrite one page for the longest merge
    for (int p = 0; p < PIB; p++) issue_request(1'b1, SECTOR_W'(200 * PIB + p));
    issue_request(1'b1, SECTOR_W'(200 * PIB + $urandom_range(0, PIB - 1)));
    random_burst(30);

    drain_wait();
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bmft_pkg.sv
hw/rtl/bmft_ctrl.sv
hw/rtl/bmft_dp.sv
hw/rtl/block_mapping_flash_translation.sv
test/block_mapping_flash_translation_checker.sv
test/block_mapping_flash_translation_tb.sv
